// ----- hdl/tes_pkg.sv -----
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants of the triangle edge split core.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int CORNER_W  = 12;
    localparam int VIDX_W    = 13;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_A_X   = 3'd0,
        CFG_EDGE_A_Y   = 3'd1,
        CFG_EDGE_A_Z   = 3'd2,
        CFG_EDGE_B_X   = 3'd3,
        CFG_EDGE_B_Y   = 3'd4,
        CFG_EDGE_B_Z   = 3'd5,
        CFG_NEW_VERTEX = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TRI  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_E01 = 2'd0,
        KIND_E02 = 2'd1,
        KIND_E12 = 2'd2
    } split_kind_t;

    typedef enum logic {
        BK_RUN   = 1'b0,
        BK_FLUSH = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } pos_t;

    typedef struct packed {
        pos_t a;
        pos_t b;
    } edge_cfg_t;

    // classified triangle handed from front to back
    typedef struct packed {
        logic [CORNER_W-1:0] c0;
        logic [CORNER_W-1:0] c1;
        logic [CORNER_W-1:0] c2;
        logic                hit;
        split_kind_t         kind;
        logic                last;
    } tri_cmd_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               empty;
        logic               full;
    } q_status_t;

    typedef struct packed {
        logic flushing;
        logic buf_empty;
    } bk_status_t;

endpackage

// ----- hdl/tes_front.sv -----
// ----------------------------------------------------------------------------
// tes_front
// Accepts load and triangle requests, keeps the vertex position store and
// classifies each triangle against the configured edge.
// ----------------------------------------------------------------------------
module tes_front
    import tes_pkg::*;
#(
    parameter int VERTS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [CORNER_W-1:0] vert_index,
    input  pos_t                pos,
    input  logic [CORNER_W-1:0] corner_a,
    input  logic [CORNER_W-1:0] corner_b,
    input  logic [CORNER_W-1:0] corner_c,
    input  logic                final_triangle,
    input  edge_cfg_t           edge_cfg,
    input  q_status_t           q_status,
    output logic                push,
    output tri_cmd_t            push_cmd
);

    localparam int AW = (VERTS > 1) ? $clog2(VERTS) : 1;
    localparam logic [Q_CNT_W:0] CREDITS = (Q_CNT_W + 1)'(Q_DEPTH);

    function automatic logic f_eq(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        a_nan     = a[COORD_W-2:0] > 31'h7F80_0000;
        b_nan     = b[COORD_W-2:0] > 31'h7F80_0000;
        both_zero = (a[COORD_W-2:0] | b[COORD_W-2:0]) == '0;
        return !a_nan && !b_nan && (both_zero || (a == b));
    endfunction

    function automatic logic pos_eq(input pos_t p, input pos_t q);
        return f_eq(p.x, q.x) && f_eq(p.y, q.y) && f_eq(p.z, q.z);
    endfunction

    logic                accept;
    logic                load_we;
    logic                tri_rd;
    logic [CORNER_W-1:0] corner [3];
    logic [2:0]          in_range;

    pos_t                rd_pos_reg [3];
    logic                s1_valid_reg;
    logic [CORNER_W-1:0] s1_corner_reg [3];
    logic [2:0]          s1_in_range_reg;
    logic                s1_last_reg;

    pos_t                p [3];
    logic [2:0]          match_a;
    logic [2:0]          match_b;

    logic                s2_valid_reg;
    logic [CORNER_W-1:0] s2_corner_reg [3];
    logic [2:0]          s2_match_a_reg;
    logic [2:0]          s2_match_b_reg;
    logic                s2_last_reg;

    logic                e01;
    logic                e02;
    logic                e12;

    assign corner[0] = corner_a;
    assign corner[1] = corner_b;
    assign corner[2] = corner_c;

    // every triangle in flight holds a queue slot
    assign in_ready = ((Q_CNT_W + 1)'(q_status.count) + (Q_CNT_W + 1)'(s1_valid_reg)
                      + (Q_CNT_W + 1)'(s2_valid_reg)) < CREDITS;
    assign accept   = in_valid && in_ready;
    assign load_we  = accept && (req_type == REQ_LOAD) && (32'(vert_index) < VERTS);
    assign tri_rd   = accept && (req_type == REQ_TRI);

    // one copy of the store per corner, each with its own read port
    for (genvar k = 0; k < 3; k++)
    begin : g_bank
        pos_t mem [VERTS];

        assign in_range[k] = 32'(corner[k]) < VERTS;

        always_ff @(posedge clk)
        begin
            if (load_we)
            begin
                mem[AW'(vert_index)] <= pos;
            end
            if (tri_rd)
            begin
                rd_pos_reg[k] <= mem[AW'(corner[k])];
            end
        end

        assign p[k]       = s1_in_range_reg[k] ? rd_pos_reg[k] : '0;
        assign match_a[k] = pos_eq(p[k], edge_cfg.a);
        assign match_b[k] = pos_eq(p[k], edge_cfg.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= tri_rd;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tri_rd)
        begin
            s1_corner_reg   <= corner;
            s1_in_range_reg <= in_range;
            s1_last_reg     <= final_triangle;
        end
        if (s1_valid_reg)
        begin
            s2_corner_reg  <= s1_corner_reg;
            s2_match_a_reg <= match_a;
            s2_match_b_reg <= match_b;
            s2_last_reg    <= s1_last_reg;
        end
    end

    assign e01 = (s2_match_a_reg[0] && s2_match_b_reg[1]) || (s2_match_a_reg[1] && s2_match_b_reg[0]);
    assign e02 = (s2_match_a_reg[0] && s2_match_b_reg[2]) || (s2_match_a_reg[2] && s2_match_b_reg[0]);
    assign e12 = (s2_match_a_reg[1] && s2_match_b_reg[2]) || (s2_match_a_reg[2] && s2_match_b_reg[1]);

    always_comb
    begin
        push_cmd.c0   = s2_corner_reg[0];
        push_cmd.c1   = s2_corner_reg[1];
        push_cmd.c2   = s2_corner_reg[2];
        push_cmd.hit  = e01 || e02 || e12;
        push_cmd.kind = e01 ? KIND_E01 : (e02 ? KIND_E02 : KIND_E12);
        push_cmd.last = s2_last_reg;
    end

    assign push = s2_valid_reg;

endmodule

// ----- hdl/tes_queue.sv -----
// ----------------------------------------------------------------------------
// tes_queue
// Short first-in first-out queue of classified triangles.
// ----------------------------------------------------------------------------
module tes_queue
    import tes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tri_cmd_t  push_cmd,
    input  logic      pop,
    output tri_cmd_t  head,
    output q_status_t status
);

    tri_cmd_t           slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == Q_CNT_W'(Q_DEPTH);

endmodule

// ----- hdl/tes_back.sv -----
// ----------------------------------------------------------------------------
// tes_back
// Passes plain triangles through, buffers split faces and flushes them as
// two halves each on the final triangle of a mesh.
// ----------------------------------------------------------------------------
module tes_back
    import tes_pkg::*;
#(
    parameter int SPLIT_MAX = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  tri_cmd_t          head,
    output logic              pop,
    input  logic [VIDX_W-1:0] new_vertex,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [VIDX_W-1:0] out_corner_a,
    output logic [VIDX_W-1:0] out_corner_b,
    output logic [VIDX_W-1:0] out_corner_c,
    output logic              from_split,
    output logic              buffer_overflow,
    output logic              mesh_done,
    output bk_status_t        status
);

    localparam int CW = $clog2(SPLIT_MAX + 1);
    localparam int IW = (SPLIT_MAX > 1) ? $clog2(SPLIT_MAX) : 1;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic              half_reg;
    logic              half_next;
    logic              overflow_reg;
    logic              overflow_next;
    tri_cmd_t          face_reg [SPLIT_MAX];

    logic              out_valid_reg;
    logic [VIDX_W-1:0] out_a_reg;
    logic [VIDX_W-1:0] out_b_reg;
    logic [VIDX_W-1:0] out_c_reg;
    logic              out_split_reg;
    logic              out_ovf_reg;
    logic              out_done_reg;

    logic              can_emit;
    logic              take;
    logic              flush_end;
    logic              face_we;
    tri_cmd_t          cur;
    logic              emit;
    logic [VIDX_W-1:0] emit_a;
    logic [VIDX_W-1:0] emit_b;
    logic [VIDX_W-1:0] emit_c;
    logic              emit_split;
    logic              emit_done;

    assign can_emit  = !out_valid_reg || out_ready;
    assign take      = (state_reg == BK_RUN) && !q_status.empty && can_emit;
    assign pop       = take;
    assign flush_end = half_reg && ((idx_reg + CW'(1)) == count_reg);
    assign cur       = face_reg[idx_reg[IW-1:0]];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (take && head.last && (head.hit || count_reg != '0))
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (can_emit && flush_end)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        half_next     = half_reg;
        overflow_next = overflow_reg;
        face_we       = 1'b0;
        emit          = 1'b0;
        emit_a        = VIDX_W'(head.c0);
        emit_b        = VIDX_W'(head.c1);
        emit_c        = VIDX_W'(head.c2);
        emit_split    = 1'b0;
        emit_done     = 1'b0;
        case (state_reg)
            BK_RUN:
            begin
                if (take)
                begin
                    if (head.hit)
                    begin
                        if (count_reg < CW'(SPLIT_MAX))
                        begin
                            face_we    = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_done = head.last && (count_reg == '0);
                    end
                    if (head.last)
                    begin
                        idx_next  = '0;
                        half_next = 1'b0;
                    end
                end
            end
            BK_FLUSH:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_split = 1'b1;
                    case (cur.kind)
                        KIND_E01:
                        begin
                            emit_a = half_reg ? VIDX_W'(cur.c1) : VIDX_W'(cur.c0);
                            emit_b = half_reg ? VIDX_W'(cur.c2) : new_vertex;
                            emit_c = half_reg ? new_vertex : VIDX_W'(cur.c2);
                        end
                        KIND_E02:
                        begin
                            emit_a = half_reg ? VIDX_W'(cur.c1) : VIDX_W'(cur.c0);
                            emit_b = half_reg ? VIDX_W'(cur.c2) : VIDX_W'(cur.c1);
                            emit_c = new_vertex;
                        end
                        KIND_E12:
                        begin
                            emit_a = half_reg ? VIDX_W'(cur.c2) : VIDX_W'(cur.c0);
                            emit_b = half_reg ? VIDX_W'(cur.c0) : VIDX_W'(cur.c1);
                            emit_c = new_vertex;
                        end
                        default:
                        begin
                            emit_a = half_reg ? VIDX_W'(cur.c2) : VIDX_W'(cur.c0);
                            emit_b = half_reg ? VIDX_W'(cur.c0) : VIDX_W'(cur.c1);
                            emit_c = new_vertex;
                        end
                    endcase
                    if (!half_reg)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        idx_next  = idx_reg + CW'(1);
                    end
                    if (flush_end)
                    begin
                        emit_done     = 1'b1;
                        count_next    = '0;
                        overflow_next = 1'b0;
                        idx_next      = '0;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            count_reg     <= '0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            half_reg     <= half_next;
            overflow_reg <= overflow_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (face_we)
        begin
            face_reg[count_reg[IW-1:0]] <= head;
        end
        if (emit)
        begin
            out_a_reg     <= emit_a;
            out_b_reg     <= emit_b;
            out_c_reg     <= emit_c;
            out_split_reg <= emit_split;
            out_ovf_reg   <= overflow_reg || (state_reg == BK_FLUSH && overflow_reg);
            out_done_reg  <= emit_done;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_corner_a    = out_a_reg;
    assign out_corner_b    = out_b_reg;
    assign out_corner_c    = out_c_reg;
    assign from_split      = out_split_reg;
    assign buffer_overflow = out_ovf_reg;
    assign mesh_done       = out_done_reg;

    assign status.flushing  = state_reg == BK_FLUSH;
    assign status.buf_empty = count_reg == '0;

endmodule

// ----- hdl/triangle_edge_split_core.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_split_core
// Splits triangles that use the configured edge around a new vertex, up to SPLIT_MAX per mesh.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    tdata, tuser = req_type, tlast = final
//  m_*       out        m_tvalid / m_tready    tdata, tuser, tlast = mesh_done
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A triangle is written into the classification queue after its accept has passed the
//  store read and compare registers; its pass-through result is then registered in the
//  output stage once popped. Pass-throughs leave at one per cycle while m_tready is high
//  and no flush runs. The flush on the final triangle emits two halves per buffered face.
//  Reset clears control state and configuration, not the position store.
//  Four triangles in the queue and its feed stages drop s_tready; m_tready stalls back up there.
// ----------------------------------------------------------------------------
module triangle_edge_split_core
    import tes_pkg::*;
#(
    parameter int VERTS     = 4096,
    parameter int SPLIT_MAX = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // vert_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [143:0]         s_tdata,
    // req_type
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_corner_a, out_corner_b, out_corner_c, zero pad
    output logic [39:0]          m_tdata,
    // from_split, buffer_overflow
    output logic [1:0]           m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    edge_cfg_t         edge_reg;
    logic [VIDX_W-1:0] new_vertex_reg;

    pos_t              in_pos;
    q_status_t         q_status;
    bk_status_t        bk_status;
    logic              push;
    tri_cmd_t          push_cmd;
    logic              pop;
    tri_cmd_t          head;
    logic [VIDX_W-1:0] out_a;
    logic [VIDX_W-1:0] out_b;
    logic [VIDX_W-1:0] out_c;
    logic              from_split;
    logic              buffer_overflow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg       <= '0;
            new_vertex_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_EDGE_A_X:   edge_reg.a.x    <= cfg_data;
                CFG_EDGE_A_Y:   edge_reg.a.y    <= cfg_data;
                CFG_EDGE_A_Z:   edge_reg.a.z    <= cfg_data;
                CFG_EDGE_B_X:   edge_reg.b.x    <= cfg_data;
                CFG_EDGE_B_Y:   edge_reg.b.y    <= cfg_data;
                CFG_EDGE_B_Z:   edge_reg.b.z    <= cfg_data;
                CFG_NEW_VERTEX: new_vertex_reg  <= cfg_data[VIDX_W-1:0];
                default:        new_vertex_reg  <= new_vertex_reg;
            endcase
        end
    end

    assign in_pos.x = s_tdata[43:12];
    assign in_pos.y = s_tdata[75:44];
    assign in_pos.z = s_tdata[107:76];

    tes_front #(
        .VERTS (VERTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .req_type       (s_tuser),
        .vert_index     (s_tdata[11:0]),
        .pos            (in_pos),
        .corner_a       (s_tdata[119:108]),
        .corner_b       (s_tdata[131:120]),
        .corner_c       (s_tdata[143:132]),
        .final_triangle (s_tlast),
        .edge_cfg       (edge_reg),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    tes_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tes_back #(
        .SPLIT_MAX (SPLIT_MAX)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .head            (head),
        .pop             (pop),
        .new_vertex      (new_vertex_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_corner_a    (out_a),
        .out_corner_b    (out_b),
        .out_corner_c    (out_c),
        .from_split      (from_split),
        .buffer_overflow (buffer_overflow),
        .mesh_done       (m_tlast),
        .status          (bk_status)
    );

    assign m_tdata = {1'b0, out_c, out_b, out_a};
    assign m_tuser = {buffer_overflow, from_split};

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("classification queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("triangle pushed into a full queue");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.flushing |-> !bk_status.buf_empty)
        else $error("flush running on an empty split buffer");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty && !bk_status.flushing)
        else $error("queue popped while empty or during flush");

endmodule
